/* hw/rtl/utf8d_pkg.sv */
package utf8d_pkg;

   // decoded code point width and result advance width
   localparam int PointWidth = 21;
   localparam int AdvWidth   = 12;
   localparam int ScaleWidth = 8;

   // job queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // marker for a malformed byte
   localparam logic [PointWidth-1:0] MarkBad = 21'h00003F;

   // configuration register indexes
   typedef enum logic {
      CSR_GLYPH_SCALE = 1'b0,
      CSR_UNUSED      = 1'b1
   } csr_index_type;

   // one queued job: some '?' marks, then optionally one decoded point
   typedef struct packed {
      logic [1:0]            bad_cnt;
      logic                  has_tail;
      logic [PointWidth-1:0] tail_cp;
   } job_type;

   // fold fullwidth ascii and apply the alias list
   function automatic logic [PointWidth-1:0] remap_point(input logic [PointWidth-1:0] cp);
      logic [PointWidth-1:0] res;
      res = cp;
      if (cp == 21'h003000) begin
         res = 21'h000020;
      end else if (cp inside {[21'h00FF01:21'h00FF5E]}) begin
         res = cp - 21'h00FEE0;
      end else if (cp == 21'h0000B5) begin
         res = 21'h0003BC;
      end else if (cp == 21'h0000F8) begin
         res = 21'h0000D8;
      end else if (cp == 21'h002126) begin
         res = 21'h0003A9;
      end else if (cp == 21'h0003D5 || cp == 21'h0003D6) begin
         res = 21'h0003C6;
      end else if (cp == 21'h0003D1 || cp == 21'h0003F4) begin
         res = 21'h0003B8;
      end else if (cp == 21'h002205) begin
         res = 21'h002300;
      end else if (cp == 21'h00223C) begin
         res = 21'h00223F;
      end
      return res;
   endfunction

endpackage

/* hw/rtl/utf8d_front.sv */
module utf8d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_text_byte,
   input  logic                queue_full,
   output logic                push,
   output utf8d_pkg::job_type  push_job
);
   import utf8d_pkg::*;

   logic [1:0]            needed_ff, needed_in;
   logic [1:0]            held_ff, held_in;
   logic [PointWidth-1:0] partial_ff, partial_in;
   logic [PointWidth-1:0] shifted;
   logic [PointWidth-1:0] raw_cp;
   logic [1:0]            held_inc;
   logic                  fresh;
   logic                  accept;
   job_type               job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // sequence tracking and job building for one word
   always_comb begin
      needed_in    = needed_ff;
      held_in      = held_ff;
      partial_in   = partial_ff;
      shifted      = {partial_ff[PointWidth-7:0], req_text_byte[5:0]};
      held_inc     = held_ff + 2'd1;
      raw_cp       = '0;
      fresh        = 1'b0;
      job.bad_cnt  = 2'd0;
      job.has_tail = 1'b0;
      if (needed_ff != 2'd0) begin
         if (req_text_byte[7:6] == 2'b10) begin
            if (held_inc >= needed_ff) begin
               raw_cp       = shifted;
               job.has_tail = 1'b1;
               needed_in    = 2'd0;
               held_in      = 2'd0;
               partial_in   = '0;
            end else begin
               held_in    = held_inc;
               partial_in = shifted;
            end
         end else begin
            // broken sequence: mark lead and held bytes, then restart
            job.bad_cnt = held_inc;
            needed_in   = 2'd0;
            held_in     = 2'd0;
            partial_in  = '0;
            fresh       = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end
      if (fresh) begin
         case (req_text_byte) inside
            8'h00: begin
            end
            [8'h01:8'h7F]: begin
               raw_cp       = {13'd0, req_text_byte};
               job.has_tail = 1'b1;
            end
            [8'hC0:8'hDF]: begin
               needed_in  = 2'd1;
               held_in    = 2'd0;
               partial_in = {16'd0, req_text_byte[4:0]};
            end
            [8'hE0:8'hEF]: begin
               needed_in  = 2'd2;
               held_in    = 2'd0;
               partial_in = {17'd0, req_text_byte[3:0]};
            end
            [8'hF0:8'hF7]: begin
               needed_in  = 2'd3;
               held_in    = 2'd0;
               partial_in = {18'd0, req_text_byte[2:0]};
            end
            default: begin
               raw_cp       = MarkBad;
               job.has_tail = 1'b1;
            end
         endcase
      end
      job.tail_cp = remap_point(raw_cp);
   end

   assign push     = accept && (job.bad_cnt != 2'd0 || job.has_tail);
   assign push_job = job;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff  <= 2'd0;
         held_ff    <= 2'd0;
         partial_ff <= '0;
      end else if (accept) begin
         needed_ff  <= needed_in;
         held_ff    <= held_in;
         partial_ff <= partial_in;
      end
   end

   // held continuation count stays below the sequence length
   a_held_below_needed: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == 2'd0) ? (held_ff == 2'd0) : (held_ff < needed_ff))
      else $error("front held count out of range");

endmodule

/* hw/rtl/utf8d_queue.sv */
module utf8d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utf8d_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output utf8d_pkg::job_type  head_job,
   output logic                empty
);
   import utf8d_pkg::*;

   job_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign full     = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // never pop an empty queue or push a full one
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty) && !(push && full))
      else $error("queue overflow or underflow");

endmodule

/* hw/rtl/utf8d_back.sv */
module utf8d_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  utf8d_pkg::job_type                   head_job,
   input  logic                                 queue_empty,
   output logic                                 pop,
   input  logic [utf8d_pkg::ScaleWidth-1:0]     glyph_scale,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [utf8d_pkg::PointWidth-1:0]     rsp_code_point,
   output logic [utf8d_pkg::AdvWidth-1:0]       rsp_advance_pixels,
   output logic                                 rsp_last_of_run
);
   import utf8d_pkg::*;

   logic                  valid_ff, valid_in;
   logic [PointWidth-1:0] cp_ff, cp_in;
   logic [AdvWidth-1:0]   adv_ff, adv_in;
   logic                  last_ff, last_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  out_free;
   logic                  step;
   logic                  emit_bad;
   logic [ScaleWidth-1:0] scale;
   logic                  narrow;

   assign out_free = !valid_ff || rsp_ready;
   assign step     = out_free && !queue_empty;
   assign emit_bad = (cnt_ff < head_job.bad_cnt);
   assign pop      = step && last_in;

   // pick the next result of the head job
   always_comb begin
      cp_in   = emit_bad ? MarkBad : head_job.tail_cp;
      last_in = emit_bad ? ((cnt_ff + 2'd1 == head_job.bad_cnt) && !head_job.has_tail) : 1'b1;
      cnt_in  = cnt_ff;
      if (step) begin
         cnt_in = last_in ? 2'd0 : cnt_ff + 2'd1;
      end
      valid_in = step ? 1'b1 : (out_free ? 1'b0 : valid_ff);
   end

   // advance: narrow glyphs are 8 wide, others 16, times the scale
   always_comb begin
      scale  = (glyph_scale == '0) ? ScaleWidth'(1) : glyph_scale;
      narrow = (cp_in < 21'h000080) || cp_in == 21'h0000B0 || cp_in == 21'h0000B2 ||
               cp_in == 21'h0000B3 || cp_in == 21'h00207B;
      adv_in = narrow ? {1'b0, scale, 3'b000} : {scale, 4'b0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (step) begin
         cp_ff   <= cp_in;
         adv_ff  <= adv_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_advance_pixels = adv_ff;
   assign rsp_last_of_run    = last_ff;

   // a job partly emitted stays at the head with marks or its tail left to send
   a_cnt_in_job: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (!queue_empty && (cnt_ff < head_job.bad_cnt ||
                            (cnt_ff == head_job.bad_cnt && head_job.has_tail))))
      else $error("back job counter out of range");

endmodule

/* hw/rtl/utf8_codepoint_decoder.sv */
// UTF-8 to code point decoder. Bytes enter on req_ (one word per cycle while
// req_ready is high) and code points leave on rsp_, each with its advance in
// pixels and a flag on the last result a byte caused. A byte gives zero to
// four results; the back end sends one result per cycle while rsp_ready
// allows, so a byte with several results holds the result side while a
// four-entry job queue lets the front keep taking bytes. The first result
// of an accepted byte passes through the queue and the back end's result
// register before it shows on rsp_. Register 0 (glyph_scale, byte address 0)
// sets the advance scale; zero acts as one. Write it only while the block is idle.
module utf8_codepoint_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_text_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [utf8d_pkg::PointWidth-1:0]     rsp_code_point,
   output logic [utf8d_pkg::AdvWidth-1:0]       rsp_advance_pixels,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [2:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import utf8d_pkg::*;

   logic [ScaleWidth-1:0] scale_ff, scale_in;
   logic                  csr_write;
   csr_index_type         csr_idx;
   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_empty;
   job_type               push_job;
   job_type               head_job;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign scale_in   = (csr_write && csr_idx == CSR_GLYPH_SCALE) ?
                       csr_pwdata[ScaleWidth-1:0] : scale_ff;
   assign csr_prdata = (csr_idx == CSR_GLYPH_SCALE) ? {24'd0, scale_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ScaleWidth'(1);
      end else begin
         scale_ff <= scale_in;
      end
   end

   // byte classification and sequence assembly
   utf8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   // job queue
   utf8d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   // result expansion
   utf8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .queue_empty        (queue_empty),
      .pop                (pop),
      .glyph_scale        (scale_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_advance_pixels (rsp_advance_pixels),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import utf8d_pkg::*;

   localparam int unsigned RunLimit    = 200000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned PhaseWords  = 51;
   localparam int          PhaseCount  = 5;

   // one result word as it leaves the block
   typedef struct packed {
      logic [PointWidth-1:0] cp;
      logic [AdvWidth-1:0]   adv;
      logic                  last;
   } glyph_out_type;

   // one row of directed stimulus, with an optional typed-in result
   typedef struct packed {
      logic [7:0]            text;
      logic                  typed;
      logic                  one_result;
      logic [PointWidth-1:0] cp;
      logic [AdvWidth-1:0]   adv;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_text_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PointWidth-1:0] rsp_code_point;
   logic [AdvWidth-1:0]   rsp_advance_pixels;
   logic                  rsp_last_of_run;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = 3'd0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // sideband that travels with the byte on the request side
   logic                  row_typed = 1'b0;
   logic                  row_one = 1'b0;
   logic [PointWidth-1:0] row_cp = '0;
   logic [AdvWidth-1:0]   row_adv = '0;

   // predictor state
   logic [ScaleWidth-1:0] glyph_scale_q = 8'd1;
   logic [1:0]            seq_needed = 2'd0;
   logic [1:0]            seq_held = 2'd0;
   logic [PointWidth-1:0] seq_point = '0;

   glyph_out_type         pending_glyphs[$];
   glyph_out_type         fresh_glyphs[$];
   int unsigned           err_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           sender_idle_pct = 0;
   int unsigned           receiver_stall_pct = 0;

   // directed rows: extremes, every lead kind, aliases, broken sequences, zero flush
   stim_row_type directed_rows [0:24] = '{
      '{8'h41, 1'b1, 1'b1, 21'h000041, 12'd8},
      '{8'h00, 1'b1, 1'b0, 21'h000000, 12'd0},
      '{8'h7F, 1'b1, 1'b1, 21'h00007F, 12'd8},
      '{8'h80, 1'b1, 1'b1, MarkBad,    12'd8},
      '{8'hFF, 1'b1, 1'b1, MarkBad,    12'd8},
      '{8'hF8, 1'b1, 1'b1, MarkBad,    12'd8},
      '{8'hC2, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hB5, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hE3, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hF7, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hF0, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h80, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h41, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hE2, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'h00, 1'b1, 1'b1, MarkBad,    12'd8},
      '{8'hC3, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hB8, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hC0, 1'b0, 1'b0, 21'h0, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h0, 12'd0}
   };

   utf8_codepoint_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_advance_pixels (rsp_advance_pixels),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RunLimit) begin
         $display("utf8_codepoint_decoder verification failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got,
               want);
      err_count++;
   endtask

   // fullwidth fold and alias list
   function automatic logic [PointWidth-1:0] fold_alias(input logic [PointWidth-1:0] cp);
      if (cp == 21'h003000) return 21'h000020;
      if (cp >= 21'h00FF01 && cp <= 21'h00FF5E) return cp - 21'h00FEE0;
      case (cp)
         21'h0000B5: return 21'h0003BC;
         21'h0000F8: return 21'h0000D8;
         21'h002126: return 21'h0003A9;
         21'h0003D5, 21'h0003D6: return 21'h0003C6;
         21'h0003D1, 21'h0003F4: return 21'h0003B8;
         21'h002205: return 21'h002300;
         21'h00223C: return 21'h00223F;
         default: return cp;
      endcase
   endfunction

   // narrow glyphs take 8 times scale, the rest 16 times
   function automatic logic [AdvWidth-1:0] advance_for(input logic [PointWidth-1:0] cp);
      logic [AdvWidth-1:0] s;
      s = (glyph_scale_q == 0) ? 12'd1 : {4'd0, glyph_scale_q};
      if (cp < 21'h80 || cp == 21'hB0 || cp == 21'hB2 || cp == 21'hB3 || cp == 21'h207B)
         return s << 3;
      return s << 4;
   endfunction

   task automatic emit_glyph(input logic [PointWidth-1:0] raw);
      logic [PointWidth-1:0] cp;
      cp = fold_alias(raw);
      fresh_glyphs.push_back('{cp, advance_for(cp), 1'b0});
   endtask

   // byte with nothing pending: ascii, a lead, or a stray mark
   task automatic open_sequence(input logic [7:0] b);
      if (b == 8'h00) begin
      end else if (b < 8'h80) begin
         emit_glyph({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
         seq_needed = 2'd1;
         seq_held   = 2'd0;
         seq_point  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         seq_needed = 2'd2;
         seq_held   = 2'd0;
         seq_point  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         seq_needed = 2'd3;
         seq_held   = 2'd0;
         seq_point  = {18'd0, b[2:0]};
      end else begin
         emit_glyph(MarkBad);
      end
   endtask

   // predicted results of one accepted byte, left in fresh_glyphs
   task automatic decode_text_byte(input logic [7:0] b);
      glyph_out_type g;
      fresh_glyphs.delete();
      if (seq_needed != 0) begin
         if (b[7:6] == 2'b10) begin
            seq_point = {seq_point[PointWidth-7:0], b[5:0]};
            seq_held  = seq_held + 2'd1;
            if (seq_held >= seq_needed) begin
               emit_glyph(seq_point);
               seq_needed = 2'd0;
               seq_held   = 2'd0;
               seq_point  = '0;
            end
         end else begin
            // broken sequence: one mark for the lead and each held byte
            for (int i = 0; i <= seq_held && i < 3; i++) emit_glyph(MarkBad);
            seq_needed = 2'd0;
            seq_held   = 2'd0;
            seq_point  = '0;
            open_sequence(b);
         end
      end else begin
         open_sequence(b);
      end
      if (fresh_glyphs.size() > 0) begin
         g = fresh_glyphs.pop_back();
         g.last = 1'b1;
         fresh_glyphs.push_back(g);
      end
   endtask

   // accepted words on both channels
   always @(posedge clock) begin : accept_monitor
      glyph_out_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_text_byte(req_text_byte);
            if (row_typed) begin
               fresh_glyphs.delete();
               if (row_one) fresh_glyphs.push_back('{row_cp, row_adv, 1'b1});
            end
            foreach (fresh_glyphs[i]) pending_glyphs.push_back(fresh_glyphs[i]);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_glyphs.size() == 0) begin
               report_mismatch("unexpected code_point", {11'd0, rsp_code_point}, 32'd0);
            end else begin
               want = pending_glyphs.pop_front();
               if (rsp_code_point !== want.cp)
                  report_mismatch("code_point", {11'd0, rsp_code_point}, {11'd0, want.cp});
               if (rsp_advance_pixels !== want.adv)
                  report_mismatch("advance_pixels", {20'd0, rsp_advance_pixels},
                                  {20'd0, want.adv});
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", {31'd0, rsp_last_of_run}, {31'd0, want.last});
            end
         end
      end
   end

   // offer one byte and hold it until the word is taken
   task automatic push_byte(input stim_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= row.text;
      row_typed     <= row.typed;
      row_one       <= row.one_result;
      row_cp        <= row.cp;
      row_adv       <= row.adv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic push_plain(input logic [7:0] b);
      push_byte('{b, 1'b0, 1'b0, 21'h0, 12'd0});
   endtask

   // one random run: mostly well-formed sequences, some broken, some noise
   task automatic send_random_run(output int unsigned n_sent);
      logic [PointWidth-1:0] cp;
      logic [PointWidth-1:0] aliases [0:15];
      logic [7:0]            text[$];
      int unsigned           pick;
      int unsigned           len;
      int unsigned           held;
      aliases = '{21'h3000, 21'hFF01, 21'hFF5E, 21'h00B5, 21'h00F8, 21'h2126, 21'h03D5,
                  21'h03D6, 21'h03D1, 21'h03F4, 21'h2205, 21'h223C, 21'h00B0, 21'h00B2,
                  21'h00B3, 21'h207B};
      pick = $urandom_range(99);
      if (pick < 60) begin
         // well-formed, overlong forms allowed
         case ($urandom_range(8))
            0, 1: begin
               cp  = PointWidth'($urandom_range(1, 127));
               len = 1;
            end
            2: begin
               cp = ($urandom_range(1) == 0) ? aliases[$urandom_range(15)]
                                             : PointWidth'($urandom_range(21'hFF01, 21'hFF5E));
               len = (cp < 21'h800) ? 2 : 3;
            end
            3, 4: begin
               cp  = PointWidth'($urandom_range(0, 21'h7FF));
               len = 2;
            end
            5, 6: begin
               cp  = PointWidth'($urandom_range(0, 21'hFFFF));
               len = 3;
            end
            default: begin
               cp  = PointWidth'($urandom_range(0, 21'h1FFFFF));
               len = 4;
            end
         endcase
         case (len)
            1: text.push_back(cp[7:0]);
            2: begin
               text.push_back({3'b110, cp[10:6]});
               text.push_back({2'b10, cp[5:0]});
            end
            3: begin
               text.push_back({4'b1110, cp[15:12]});
               text.push_back({2'b10, cp[11:6]});
               text.push_back({2'b10, cp[5:0]});
            end
            default: begin
               text.push_back({5'b11110, cp[20:18]});
               text.push_back({2'b10, cp[17:12]});
               text.push_back({2'b10, cp[11:6]});
               text.push_back({2'b10, cp[5:0]});
            end
         endcase
      end else if (pick < 75) begin
         // lead, too few continuation bytes, then a breaker
         len = $urandom_range(1, 3);
         case (len)
            1: text.push_back({3'b110, 5'($urandom)});
            2: text.push_back({4'b1110, 4'($urandom)});
            default: text.push_back({5'b11110, 3'($urandom)});
         endcase
         held = $urandom_range(0, len - 1);
         repeat (held) text.push_back({2'b10, 6'($urandom)});
         case ($urandom_range(3))
            0: text.push_back(8'h00);
            1: text.push_back(8'($urandom_range(1, 127)));
            2: text.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            default: text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         endcase
      end else if (pick < 85) begin
         text.push_back(8'h00);
      end else begin
         text.push_back(8'($urandom_range(255)));
      end
      n_sent = 0;
      foreach (text[i]) begin
         push_plain(text[i]);
         n_sent++;
      end
   endtask

   // let every expected word arrive, then let the block settle
   task automatic wait_drained();
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == CSR_GLYPH_SCALE) glyph_scale_q = data[ScaleWidth-1:0];
   endtask

   // read back the scale register
   task automatic csr_check_scale();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {CSR_GLYPH_SCALE, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {24'd0, glyph_scale_q})
         report_mismatch("glyph_scale readback", csr_prdata, {24'd0, glyph_scale_q});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // main sequence
   initial begin : stimulus
      logic [ScaleWidth-1:0] scales [0:PhaseCount-1];
      int unsigned           idle_modes [0:PhaseCount-1];
      int unsigned           stall_modes [0:PhaseCount-1];
      int unsigned           sent;
      int unsigned           n;
      scales      = '{8'd0, 8'd255, 8'd2, 8'($urandom_range(3, 254)), 8'd128};
      idle_modes  = '{0, 71, 0, 36, 0};
      stall_modes = '{0, 0, 71, 36, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_scale();

      // directed part at reset scale, no idling
      foreach (directed_rows[i]) push_byte(directed_rows[i]);
      req_valid <= 1'b0;
      wait_drained();

      // random phases, each with its own scale and idling
      for (int p = 0; p < PhaseCount; p++) begin
         csr_write(CSR_UNUSED, $urandom);
         csr_write(CSR_GLYPH_SCALE, {24'($urandom), scales[p]});
         csr_check_scale();
         sender_idle_pct    = idle_modes[p];
         receiver_stall_pct = stall_modes[p];
         sent = 0;
         while (sent < PhaseWords) begin
            send_random_run(n);
            sent += n;
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      if (err_count == 0) begin
         $display("utf8_codepoint_decoder verification clean");
      end else begin
         $display("utf8_codepoint_decoder verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_front.sv
hw/rtl/utf8d_queue.sv
hw/rtl/utf8d_back.sv
hw/rtl/utf8_codepoint_decoder.sv
tb/sv/testbench.sv
